>>> rtl/rbs_pkg.sv
`default_nettype none

package rbs_pkg;

    typedef logic [31:0] f32_t;

    // Stage counts: subtract 3, multiply 3, min/max 1, output register 1
    localparam int PIPE_DEPTH = 8;
    localparam int SIDE_DEPTH = 6;
    localparam int NUM_AXES   = 3;

    localparam logic [7:0]  EXP_MAX = 8'hFF;
    localparam f32_t        QNAN    = 32'h7FC0_0000;

    typedef struct packed {
        logic [NUM_AXES-1:0] neg;
        f32_t [NUM_AXES-1:0] inv;
        f32_t                win_lo;
        f32_t                win_hi;
    } side_t;

    function automatic logic f_is_nan(input f32_t a);
        return (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic f_is_zero(input f32_t a);
        return a[30:0] == 31'd0;
    endfunction

    // IEEE less-than: false on NaN, signed zeros equal
    function automatic logic f_lt(input f32_t a, input f32_t b);
        logic r;
        if (f_is_nan(a) || f_is_nan(b))
            r = 1'b0;
        else if (f_is_zero(a) && f_is_zero(b))
            r = 1'b0;
        else if (a[31] != b[31])
            r = a[31];
        else if (!a[31])
            r = a[30:0] < b[30:0];
        else
            r = a[30:0] > b[30:0];
        return r;
    endfunction

    function automatic logic f_le(input f32_t a, input f32_t b);
        logic eq;
        eq = (a == b) || (f_is_zero(a) && f_is_zero(b));
        return !f_is_nan(a) && !f_is_nan(b) && (eq || f_lt(a, b));
    endfunction

    function automatic f32_t f_max(input f32_t a, input f32_t b);
        return f_lt(b, a) ? a : b;
    endfunction

    function automatic f32_t f_min(input f32_t a, input f32_t b);
        return f_lt(a, b) ? a : b;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rbs_in_if.sv
`default_nettype none

interface rbs_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [31:0] origin_z;
    logic [31:0] inv_dir_x;
    logic [31:0] inv_dir_y;
    logic [31:0] inv_dir_z;
    logic [63:0] box_x_bounds;
    logic [63:0] box_y_bounds;
    logic [63:0] box_z_bounds;
    logic [63:0] t_window;

    modport source (
        output valid, origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
               box_x_bounds, box_y_bounds, box_z_bounds, t_window,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
               box_x_bounds, box_y_bounds, box_z_bounds, t_window,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/rbs_out_if.sv
`default_nettype none

interface rbs_out_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

`default_nettype wire

>>> rtl/rbs_fsub.sv
`default_nettype none

// Single-precision a - b, round to nearest even, three register stages
module rbs_fsub (
    input  wire logic         clk,
    input  wire logic         en,
    input  rbs_pkg::f32_t     a,
    input  rbs_pkg::f32_t     b,
    output rbs_pkg::f32_t     diff
);
    import rbs_pkg::*;

    // stage 1: swap by magnitude and align
    logic        s1_sign_reg, s1_sign_next;
    logic [7:0]  s1_exp_reg, s1_exp_next;
    logic [26:0] s1_mx_reg, s1_mx_next;
    logic [26:0] s1_my_reg, s1_my_next;
    logic        s1_sub_reg, s1_sub_next;
    logic        s1_nan_reg, s1_nan_next;
    logic        s1_inf_reg, s1_inf_next;
    logic        s1_infs_reg, s1_infs_next;

    always_comb
    begin
        logic        sa, sb, a_nan, b_nan, a_inf, b_inf, swap, sy, lost;
        logic [7:0]  ea, eb, ex, ey, d;
        logic [23:0] ma, mb, my;
        logic [26:0] my27, sh, mask;
        sa    = a[31];
        sb    = ~b[31];
        ea    = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma    = {(a[30:23] != 8'd0), a[22:0]};
        mb    = {(b[30:23] != 8'd0), b[22:0]};
        a_nan = f_is_nan(a);
        b_nan = f_is_nan(b);
        a_inf = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
        b_inf = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
        swap  = b[30:0] > a[30:0];
        s1_sign_next = swap ? sb : sa;
        sy    = swap ? sa : sb;
        ex    = swap ? eb : ea;
        ey    = swap ? ea : eb;
        s1_mx_next = {(swap ? mb : ma), 3'b000};
        my    = swap ? ma : mb;
        d     = ex - ey;
        my27  = {my, 3'b000};
        sh    = my27 >> d;
        mask  = ~({27{1'b1}} << d);
        lost  = |(my27 & mask);
        s1_my_next   = {sh[26:1], sh[0] | lost};
        s1_exp_next  = ex;
        s1_sub_next  = s1_sign_next != sy;
        s1_nan_next  = a_nan || b_nan || (a_inf && b_inf && (sa != sb));
        s1_inf_next  = a_inf || b_inf;
        s1_infs_next = a_inf ? sa : sb;
    end

    // stage 2: add and normalize
    logic        s2_sign_reg;
    logic [26:0] s2_n_reg, s2_n_next;
    logic        s2_stk_reg, s2_stk_next;
    logic [8:0]  s2_exp_reg, s2_exp_next;
    logic        s2_nan_reg, s2_inf_reg, s2_infs_reg;

    always_comb
    begin
        logic [27:0] sum;
        logic [4:0]  lz, lim, sh;
        sum = s1_sub_reg ? ({1'b0, s1_mx_reg} - {1'b0, s1_my_reg})
                         : ({1'b0, s1_mx_reg} + {1'b0, s1_my_reg});
        lz = 5'd27;
        for (int i = 0; i < 27; i++)
        begin
            if (sum[i])
                lz = 5'(26 - i);
        end
        lim = (s1_exp_reg > 8'd27) ? 5'd27 : 5'(s1_exp_reg - 8'd1);
        sh  = (lz < lim) ? lz : lim;
        if (sum[27])
        begin
            s2_n_next   = sum[27:1];
            s2_stk_next = sum[0];
            s2_exp_next = {1'b0, s1_exp_reg} + 9'd1;
        end
        else
        begin
            s2_n_next   = sum[26:0] << sh;
            s2_stk_next = 1'b0;
            s2_exp_next = {1'b0, s1_exp_reg} - {4'd0, sh};
        end
    end

    // stage 3: round and pack
    f32_t diff_reg, diff_next;

    always_comb
    begin
        logic [7:0]  expf;
        logic        up;
        logic [30:0] mag;
        expf = s2_n_reg[26] ? s2_exp_reg[7:0] : 8'd0;
        up   = s2_n_reg[2] & (s2_n_reg[1] | s2_n_reg[0] | s2_stk_reg | s2_n_reg[3]);
        mag  = {expf, s2_n_reg[25:3]} + {30'd0, up};
        if (s2_nan_reg)
            diff_next = QNAN;
        else if (s2_inf_reg)
            diff_next = {s2_infs_reg, EXP_MAX, 23'd0};
        else if (s2_exp_reg >= 9'd255)
            diff_next = {s2_sign_reg, EXP_MAX, 23'd0};
        else
            diff_next = {s2_sign_reg, mag};
    end

    // advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sign_reg <= s1_sign_next;
            s1_exp_reg  <= s1_exp_next;
            s1_mx_reg   <= s1_mx_next;
            s1_my_reg   <= s1_my_next;
            s1_sub_reg  <= s1_sub_next;
            s1_nan_reg  <= s1_nan_next;
            s1_inf_reg  <= s1_inf_next;
            s1_infs_reg <= s1_infs_next;
            s2_sign_reg <= s1_sign_reg;
            s2_n_reg    <= s2_n_next;
            s2_stk_reg  <= s2_stk_next;
            s2_exp_reg  <= s2_exp_next;
            s2_nan_reg  <= s1_nan_reg;
            s2_inf_reg  <= s1_inf_reg;
            s2_infs_reg <= s1_infs_reg;
            diff_reg    <= diff_next;
        end
    end

    assign diff = diff_reg;

endmodule

`default_nettype wire

>>> rtl/rbs_fmul.sv
`default_nettype none

// Single-precision a * b, round to nearest even, three register stages
module rbs_fmul (
    input  wire logic         clk,
    input  wire logic         en,
    input  rbs_pkg::f32_t     a,
    input  rbs_pkg::f32_t     b,
    output rbs_pkg::f32_t     prod
);
    import rbs_pkg::*;

    // stage 1: unpack and multiply significands
    logic        m1_sign_reg, m1_sign_next;
    logic [47:0] m1_p_reg, m1_p_next;
    logic [8:0]  m1_esum_reg, m1_esum_next;
    logic        m1_nan_reg, m1_nan_next;
    logic        m1_inf_reg, m1_inf_next;
    logic        m1_zero_reg, m1_zero_next;

    always_comb
    begin
        logic        a_inf, b_inf, a_zero, b_zero;
        logic [23:0] ma, mb;
        logic [7:0]  ea, eb;
        a_inf  = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
        b_inf  = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
        a_zero = f_is_zero(a);
        b_zero = f_is_zero(b);
        ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma     = {(a[30:23] != 8'd0), a[22:0]};
        mb     = {(b[30:23] != 8'd0), b[22:0]};
        m1_sign_next = a[31] ^ b[31];
        m1_p_next    = ma * mb;
        m1_esum_next = {1'b0, ea} + {1'b0, eb};
        m1_nan_next  = f_is_nan(a) || f_is_nan(b) || (a_inf && b_zero) || (b_inf && a_zero);
        m1_inf_next  = a_inf || b_inf;
        m1_zero_next = a_zero || b_zero;
    end

    // stage 2: normalize to the top bit and form the exponent
    logic               m2_sign_reg, m2_nan_reg, m2_inf_reg, m2_zero_reg;
    logic [47:0]        m2_n_reg, m2_n_next;
    logic signed [10:0] m2_exp_reg, m2_exp_next;

    always_comb
    begin
        logic [5:0] lz;
        lz = 6'd47;
        for (int i = 0; i < 48; i++)
        begin
            if (m1_p_reg[i])
                lz = 6'(47 - i);
        end
        m2_n_next   = m1_p_reg << lz;
        m2_exp_next = signed'({2'b00, m1_esum_reg}) - 11'sd126 - signed'({5'd0, lz});
    end

    // stage 3: denormalize, round and pack
    f32_t prod_reg, prod_next;

    always_comb
    begin
        logic [47:0]        m, mask;
        logic               lost, up;
        logic [7:0]         expf;
        logic signed [10:0] k;
        logic [30:0]        mag;
        k    = 11'sd1 - m2_exp_reg;
        mask = ~({48{1'b1}} << k[7:0]);
        if (m2_exp_reg >= 11'sd1)
        begin
            m    = m2_n_reg;
            lost = 1'b0;
            expf = m2_exp_reg[7:0];
        end
        else
        begin
            m    = m2_n_reg >> k[7:0];
            lost = |(m2_n_reg & mask);
            expf = 8'd0;
        end
        up  = m[23] & ((|m[22:0]) | lost | m[24]);
        mag = {expf, m[46:24]} + {30'd0, up};
        if (m2_nan_reg)
            prod_next = QNAN;
        else if (m2_inf_reg)
            prod_next = {m2_sign_reg, EXP_MAX, 23'd0};
        else if (m2_zero_reg)
            prod_next = {m2_sign_reg, 31'd0};
        else if (m2_exp_reg >= 11'sd255)
            prod_next = {m2_sign_reg, EXP_MAX, 23'd0};
        else
            prod_next = {m2_sign_reg, mag};
    end

    // advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_sign_reg <= m1_sign_next;
            m1_p_reg    <= m1_p_next;
            m1_esum_reg <= m1_esum_next;
            m1_nan_reg  <= m1_nan_next;
            m1_inf_reg  <= m1_inf_next;
            m1_zero_reg <= m1_zero_next;
            m2_sign_reg <= m1_sign_reg;
            m2_n_reg    <= m2_n_next;
            m2_exp_reg  <= m2_exp_next;
            m2_nan_reg  <= m1_nan_reg;
            m2_inf_reg  <= m1_inf_reg;
            m2_zero_reg <= m1_zero_reg;
            prod_reg    <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

>>> rtl/rbs_hit.sv
`default_nettype none

// Entry/exit reduction, then the overlap and window test
module rbs_hit (
    input  wire logic                                    clk,
    input  wire logic                                    en,
    input  rbs_pkg::f32_t [rbs_pkg::NUM_AXES-1:0]        t_lo,
    input  rbs_pkg::f32_t [rbs_pkg::NUM_AXES-1:0]        t_hi,
    input  rbs_pkg::side_t                               side,
    output logic                                         hit
);
    import rbs_pkg::*;

    f32_t entry_reg, entry_next;
    f32_t exit_reg, exit_next;
    f32_t win_lo_reg, win_hi_reg;
    logic hit_reg, hit_next;

    // pick near/far per axis, then max of near and min of far
    always_comb
    begin
        f32_t [NUM_AXES-1:0] near_t, far_t;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            near_t[i] = side.neg[i] ? t_hi[i] : t_lo[i];
            far_t[i]  = side.neg[i] ? t_lo[i] : t_hi[i];
        end
        entry_next = f_max(f_max(near_t[0], near_t[1]), near_t[2]);
        exit_next  = f_min(f_min(far_t[0], far_t[1]), far_t[2]);
    end

    // inclusive window on the entry distance
    assign hit_next = f_le(entry_reg, exit_reg) && f_le(win_lo_reg, entry_reg)
                      && f_le(entry_reg, win_hi_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            entry_reg  <= entry_next;
            exit_reg   <= exit_next;
            win_lo_reg <= side.win_lo;
            win_hi_reg <= side.win_hi;
            hit_reg    <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

`default_nettype wire

>>> rtl/ray_box_slab_test.sv
// Ray versus axis-aligned box slab test in IEEE single precision.
// Each request passes the subtract, multiply, min/max and output stages.
// Throughput: one request per cycle; the subtract, multiply and compare
// pipelines are fully staged and stall as one when the result is not taken.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers keep
// whatever they hold.
`default_nettype none

module ray_box_slab_test (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rbs_in_if.sink     ray,
    rbs_out_if.source  result
);
    import rbs_pkg::*;

    logic                      adv;
    logic [PIPE_DEPTH-1:0]     vld_reg;
    side_t                     side_reg [SIDE_DEPTH];
    side_t                     side_next;
    f32_t [NUM_AXES-1:0]       org, inv, bnd_lo, bnd_hi;
    f32_t [NUM_AXES-1:0]       d_lo, d_hi, t_lo, t_hi;
    logic                      hit;

    // advance when the output register is empty or being drained
    assign adv       = !vld_reg[PIPE_DEPTH-1] || result.ready;
    assign ray.ready = adv;

    assign org    = {ray.origin_z, ray.origin_y, ray.origin_x};
    assign inv    = {ray.inv_dir_z, ray.inv_dir_y, ray.inv_dir_x};
    assign bnd_lo = {ray.box_z_bounds[31:0], ray.box_y_bounds[31:0], ray.box_x_bounds[31:0]};
    assign bnd_hi = {ray.box_z_bounds[63:32], ray.box_y_bounds[63:32],
                     ray.box_x_bounds[63:32]};

    // flag axes with a negative reciprocal direction
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
            side_next.neg[i] = f_lt(inv[i], 32'd0);
        side_next.inv    = inv;
        side_next.win_lo = ray.t_window[31:0];
        side_next.win_hi = ray.t_window[63:32];
    end

    // slab distances per axis
    for (genvar g = 0; g < NUM_AXES; g++)
    begin : g_axis
        rbs_fsub u_sub_lo (.clk(clk), .en(adv), .a(bnd_lo[g]), .b(org[g]), .diff(d_lo[g]));
        rbs_fsub u_sub_hi (.clk(clk), .en(adv), .a(bnd_hi[g]), .b(org[g]), .diff(d_hi[g]));
        rbs_fmul u_mul_lo (.clk(clk), .en(adv), .a(d_lo[g]), .b(side_reg[2].inv[g]),
                           .prod(t_lo[g]));
        rbs_fmul u_mul_hi (.clk(clk), .en(adv), .a(d_hi[g]), .b(side_reg[2].inv[g]),
                           .prod(t_hi[g]));
    end

    rbs_hit u_hit (
        .clk  (clk),
        .en   (adv),
        .t_lo (t_lo),
        .t_hi (t_hi),
        .side (side_reg[SIDE_DEPTH-1]),
        .hit  (hit)
    );

    // carry valid bits alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], ray.valid};
    end

    // carry ray side data to the stages that use it
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_next;
            for (int i = 1; i < SIDE_DEPTH; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    assign result.valid = vld_reg[PIPE_DEPTH-1];
    assign result.hit   = hit;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

    a_shift: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> vld_reg[PIPE_DEPTH-1:1] == $past(vld_reg[PIPE_DEPTH-2:0]))
        else $error("valid bits did not advance in step");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (ray.valid && ray.ready) |=> vld_reg[0])
        else $error("accepted request not tracked");

    a_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> result.valid && $stable(result.hit))
        else $error("result changed while held");

endmodule

`default_nettype wire
